/* rtl/cda_pkg.sv */
// Package for the calendar date advance block: month lengths, leap-year constants,
// and the microcode ROM with its control word types.
// Depends on nothing; every other file in rtl/ uses it.
package cda_pkg;

  localparam int unsigned YearW  = 16;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned CountW = 16;
  // Working day count: the largest day of month plus the largest advance.
  localparam int unsigned WdayW  = 17;

  localparam logic [YearW-1:0]  YearMax  = 16'hFFFF;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [DayW-1:0]   DayLast  = 5'd31;
  localparam logic [DayW-1:0]   FebLeap  = 5'd29;

  // Reciprocal of 25: q = (x * Recip25) >> Recip25Sh is exact for x below 2^14.
  localparam logic [12:0] Recip25   = 13'd5243;
  localparam int unsigned Recip25Sh = 17;

  typedef logic [DayW-1:0] mlen_t;
  localparam mlen_t MonthLen [16] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
  };

  // Length of a month, zero for a month code outside January to December.
  function automatic logic [DayW-1:0] days_in(input logic [MonthW-1:0] m, input logic leap);
    logic [DayW-1:0] len;
    len = MonthLen[m];
    if (m == 4'd2 && leap) begin
      len = FebLeap;
    end
    return len;
  endfunction

  typedef enum logic [2:0] {
    STEP_IDLE  = 3'd0,
    STEP_LEAP1 = 3'd1,
    STEP_LEAP2 = 3'd2,
    STEP_SET   = 3'd3,
    STEP_MONTH = 3'd4,
    STEP_EMIT  = 3'd5
  } step_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LEAP1,
    OP_LEAP2,
    OP_SET,
    OP_MONTH,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ACCEPT,
    COND_ADVANCE,
    COND_DONE,
    COND_NEWYEAR,
    COND_OUTFREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond_a;
    step_t jump_a;
    cond_t cond_b;
    step_t jump_b;
    step_t next;
  } uword_t;

  // Microcode ROM. Condition A takes priority over condition B; otherwise next.
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    case (step)
      STEP_IDLE:  w = '{OP_IDLE,  COND_ACCEPT,  STEP_LEAP1, COND_NEVER,   STEP_IDLE,  STEP_IDLE};
      STEP_LEAP1: w = '{OP_LEAP1, COND_NEVER,   STEP_IDLE,  COND_NEVER,   STEP_IDLE,  STEP_LEAP2};
      STEP_LEAP2: w = '{OP_LEAP2, COND_ADVANCE, STEP_MONTH, COND_NEVER,   STEP_IDLE,  STEP_SET};
      STEP_SET:   w = '{OP_SET,   COND_NEVER,   STEP_IDLE,  COND_NEVER,   STEP_IDLE,  STEP_EMIT};
      STEP_MONTH: w = '{OP_MONTH, COND_DONE,    STEP_EMIT,  COND_NEWYEAR, STEP_LEAP1, STEP_MONTH};
      STEP_EMIT:  w = '{OP_EMIT,  COND_OUTFREE, STEP_IDLE,  COND_NEVER,   STEP_IDLE,  STEP_EMIT};
      default:    w = '{OP_IDLE,  COND_NEVER,   STEP_IDLE,  COND_NEVER,   STEP_IDLE,  STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/cda_in_if.sv */
// Command channel of the calendar date advance block: valid/ready and the item fields.
// Depends on cda_pkg for the field widths.
interface cda_in_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [cda_pkg::YearW-1:0]      year_in;
  logic [cda_pkg::MonthW-1:0]     month_in;
  logic [cda_pkg::DayW-1:0]       day_in;
  logic [cda_pkg::CountW-1:0]     days_to_add;

  modport source (output valid, kind, year_in, month_in, day_in, days_to_add, input ready);
  modport sink   (input valid, kind, year_in, month_in, day_in, days_to_add, output ready);
endinterface

/* rtl/cda_out_if.sv */
// Result channel of the calendar date advance block: valid/ready and the date fields.
// Depends on cda_pkg for the field widths.
interface cda_out_if;
  logic                       valid;
  logic                       ready;
  logic [cda_pkg::YearW-1:0]  year_out;
  logic [cda_pkg::MonthW-1:0] month_out;
  logic [cda_pkg::DayW-1:0]   day_out;
  logic                       error;

  modport source (output valid, year_out, month_out, day_out, error, input ready);
  modport sink   (input valid, year_out, month_out, day_out, error, output ready);
endinterface

/* rtl/calendar_date_advance.sv */
// Calendar date advance, top level: a Gregorian date register driven by a microcoded sequencer.
// Depends on cda_pkg, cda_in_if and cda_out_if.

// The block holds one Gregorian date, reset to year 1, January 1st, and answers every
// command beat with one result beat carrying the date it holds afterwards. A set command
// loads year, month and day if the date is real (year not zero, month 1 to 12, day within
// the month, February having 29 days in leap years); otherwise error is raised and the
// date is kept. An advance command moves the date forward by days_to_add days; if it
// would pass the last day of year 65535, the date stops at 65535-12-31 with error raised.
// Error is never sticky. Commands are handled one at a time by a six-step microprogram:
// a set runs the leap test, the set check and the emit step; an advance runs the leap
// test and then steps one month at a time until the date fits or saturates, redoing the
// leap test for each new year entered, and then emits. The month-stepping loop thus sets
// how long an advance runs. The result sits in an output register, so the next command
// is taken while a result still waits, and a result waits in the final step only if the
// register before it has not yet been taken.

module calendar_date_advance (
  input  logic      clk,
  input  logic      rst,
  cda_in_if.sink    cmd,
  cda_out_if.source rsp
);

  // Sequencer.
  cda_pkg::step_t  step;
  cda_pkg::step_t  step_next;
  cda_pkg::uword_t uw;

  // Committed date.
  logic [cda_pkg::YearW-1:0]  cur_year;
  logic [cda_pkg::MonthW-1:0] cur_month;
  logic [cda_pkg::DayW-1:0]   cur_day;

  // Latched command and working registers.
  logic                        kind;
  logic [cda_pkg::YearW-1:0]   set_year;
  logic [cda_pkg::MonthW-1:0]  set_month;
  logic [cda_pkg::DayW-1:0]    set_day;
  logic [cda_pkg::YearW-1:0]   wyear;
  logic [cda_pkg::MonthW-1:0]  wmonth;
  logic [cda_pkg::WdayW-1:0]   wday;
  logic [cda_pkg::YearW-1:0]   lyear;    // year under the leap test
  logic [9:0]                  q4;       // (lyear / 4) / 25
  logic [9:0]                  q16;      // (lyear / 16) / 25
  logic                        leap;
  logic                        err;

  // Result register.
  logic                        rsp_valid;
  logic [cda_pkg::YearW-1:0]   rsp_year;
  logic [cda_pkg::MonthW-1:0]  rsp_month;
  logic [cda_pkg::DayW-1:0]    rsp_day;
  logic                        rsp_error;

  // Datapath terms.
  logic                        accept;
  logic                        out_free;
  logic [26:0]                 prod4;
  logic [26:0]                 prod16;
  logic [14:0]                 chk4;
  logic [14:0]                 chk16;
  logic                        div100;
  logic                        div400;
  logic                        leap_now;
  logic [cda_pkg::DayW-1:0]    set_len;
  logic                        set_ok;
  logic [cda_pkg::DayW-1:0]    wlen;
  logic                        fits;
  logic                        saturate;
  logic                        done;
  logic                        newyear;
  logic [cda_pkg::YearW-1:0]   wyear_inc;

  assign accept   = cmd.valid && cmd.ready;
  assign out_free = !rsp_valid || rsp.ready;
  assign cmd.ready = (step == cda_pkg::STEP_IDLE);

  assign rsp.valid     = rsp_valid;
  assign rsp.year_out  = rsp_year;
  assign rsp.month_out = rsp_month;
  assign rsp.day_out   = rsp_day;
  assign rsp.error     = rsp_error;

  // Leap test in two steps: quotients by 25 through a reciprocal multiply, then a check
  // that the quotient times 25 gives back the operand (exact division).
  assign prod4  = {13'd0, lyear[15:2]} * {14'd0, cda_pkg::Recip25};
  assign prod16 = {15'd0, lyear[15:4]} * {14'd0, cda_pkg::Recip25};
  assign chk4   = {5'd0, q4} + {1'b0, q4, 4'd0} + {2'b0, q4, 3'd0};
  assign chk16  = {5'd0, q16} + {1'b0, q16, 4'd0} + {2'b0, q16, 3'd0};
  assign div100 = (chk4 == {1'b0, lyear[15:2]});
  assign div400 = (lyear[3:0] == 4'd0) && (chk16 == {3'd0, lyear[15:4]});
  assign leap_now = (lyear[1:0] == 2'd0) && (!div100 || div400);

  // Set check against the latched fields.
  assign set_len = cda_pkg::days_in(set_month, leap);
  assign set_ok  = (set_year != '0) && (set_len != '0) && (set_day != '0)
                   && (set_day <= set_len);

  // One month of carry.
  assign wlen      = cda_pkg::days_in(wmonth, leap);
  assign fits      = (wday <= {{(cda_pkg::WdayW-cda_pkg::DayW){1'b0}}, wlen});
  assign saturate  = !fits && (wmonth == cda_pkg::MonthDec) && (wyear == cda_pkg::YearMax);
  assign done      = fits || saturate;
  assign newyear   = (wmonth == cda_pkg::MonthDec);
  assign wyear_inc = wyear + 16'd1;

  // Sequencer: pick the next step from the control word.
  always_comb begin
    logic hit_a;
    logic hit_b;
    uw = cda_pkg::ucode(step);
    case (uw.cond_a)
      cda_pkg::COND_ACCEPT:  hit_a = accept;
      cda_pkg::COND_ADVANCE: hit_a = kind;
      cda_pkg::COND_DONE:    hit_a = done;
      cda_pkg::COND_NEWYEAR: hit_a = newyear;
      cda_pkg::COND_OUTFREE: hit_a = out_free;
      default:               hit_a = 1'b0;
    endcase
    case (uw.cond_b)
      cda_pkg::COND_ACCEPT:  hit_b = accept;
      cda_pkg::COND_ADVANCE: hit_b = kind;
      cda_pkg::COND_DONE:    hit_b = done;
      cda_pkg::COND_NEWYEAR: hit_b = newyear;
      cda_pkg::COND_OUTFREE: hit_b = out_free;
      default:               hit_b = 1'b0;
    endcase
    if (hit_a) begin
      step_next = uw.jump_a;
    end else if (hit_b) begin
      step_next = uw.jump_b;
    end else begin
      step_next = uw.next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= cda_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Datapath, driven by the op field of the control word.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_year  <= 16'd1;
      cur_month <= 4'd1;
      cur_day   <= 5'd1;
      rsp_valid <= 1'b0;
    end else begin
      // A taken result empties the register unless a new one is loaded in the same cycle.
      if (rsp_valid && rsp.ready && !(uw.op == cda_pkg::OP_EMIT && out_free)) begin
        rsp_valid <= 1'b0;
      end
      case (uw.op)
        cda_pkg::OP_IDLE: begin
          if (accept) begin
            kind      <= cmd.kind;
            set_year  <= cmd.year_in;
            set_month <= cmd.month_in;
            set_day   <= cmd.day_in;
            wyear     <= cur_year;
            wmonth    <= cur_month;
            wday      <= {{(cda_pkg::WdayW-cda_pkg::DayW){1'b0}}, cur_day}
                         + {1'b0, cmd.days_to_add};
            lyear     <= cmd.kind ? cur_year : cmd.year_in;
            err       <= 1'b0;
          end
        end
        cda_pkg::OP_LEAP1: begin
          q4  <= prod4[cda_pkg::Recip25Sh +: 10];
          q16 <= prod16[cda_pkg::Recip25Sh +: 10];
        end
        cda_pkg::OP_LEAP2: begin
          leap <= leap_now;
        end
        cda_pkg::OP_SET: begin
          if (set_ok) begin
            cur_year  <= set_year;
            cur_month <= set_month;
            cur_day   <= set_day;
          end else begin
            err <= 1'b1;
          end
        end
        cda_pkg::OP_MONTH: begin
          if (fits) begin
            cur_year  <= wyear;
            cur_month <= wmonth;
            cur_day   <= wday[cda_pkg::DayW-1:0];
          end else if (saturate) begin
            cur_year  <= cda_pkg::YearMax;
            cur_month <= cda_pkg::MonthDec;
            cur_day   <= cda_pkg::DayLast;
            err       <= 1'b1;
          end else begin
            wday <= wday - {{(cda_pkg::WdayW-cda_pkg::DayW){1'b0}}, wlen};
            if (newyear) begin
              wmonth <= cda_pkg::MonthJan;
              wyear  <= wyear_inc;
              lyear  <= wyear_inc;
            end else begin
              wmonth <= wmonth + 4'd1;
            end
          end
        end
        cda_pkg::OP_EMIT: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            rsp_year  <= cur_year;
            rsp_month <= cur_month;
            rsp_day   <= cur_day;
            rsp_error <= err;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
